// ----- rtl/log_binned_histogram_defines.svh -----
// assertion macros used by the histogram controller rtl
`ifndef LOG_BINNED_HISTOGRAM_DEFINES_SVH
`define LOG_BINNED_HISTOGRAM_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LBH_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define LBH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lbh_pkg.sv -----
// shared types and constants of the log-binned histogram
package lbh_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_WR_EDGE = 2'd1,
    OP_ADD     = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic [0:0] REG_BINS_IN_USE = 1'b0;
  localparam logic [0:0] REG_LOWER_LIMIT = 1'b1;

  localparam int unsigned FRAC_W        = 32;
  localparam int unsigned STEP_W        = 6;
  localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(FRAC_W);
  localparam logic [FRAC_W:0]   ZERO_FRACTION = 33'd43;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch item fields, issue table read at bin_index
    logic edge_wr;    // write edge table
    logic total_inc;  // saturating total increment
    logic total_clr;  // zero the total
    logic sweep;      // zero one count entry
    logic scan;       // one step of the edge search
    logic div_start;  // capture read data, set up divider
    logic div_step;   // one quotient bit
    logic out_load;   // move result into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic scan_hit;
    logic scan_end;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/lbh_datapath.sv -----
// histogram datapath: tables, total, edge search and fraction divider
module lbh_datapath #(
  parameter int unsigned MAX_BINS    = 64,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [0:0]                cfg_index,
  input  logic [31:0]               cfg_data,
  input  logic [5:0]                in_bin_index,
  input  logic [31:0]               in_value,
  input  lbh_pkg::cmd_t             cmd,
  output lbh_pkg::sts_t             sts,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic [5:0]                out_read_bin,
  output logic [31:0]               out_edge_value,
  output logic [31:0]               out_bin_count,
  output logic [lbh_pkg::FRAC_W:0]  out_fraction
);
  import lbh_pkg::*;

  // table depth is min(MAX_BINS,64); only bins 0..DEPTH-1 are addressable
  localparam int unsigned DEPTH = (MAX_BINS < 64) ? MAX_BINS : 64;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned UW    = IDX_W + 1;
  localparam int unsigned CW    = COUNT_WIDTH;

  // configuration
  logic [6:0]  bins_in_use_r;
  logic [31:0] lower_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_in_use_r <= 7'd64;
      lower_limit_r <= 32'd83886;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BINS_IN_USE: bins_in_use_r <= cfg_data[6:0];
        REG_LOWER_LIMIT: lower_limit_r <= cfg_data;
      endcase
    end
  end

  logic [UW-1:0] used;
  assign used = (bins_in_use_r > 7'(DEPTH)) ? UW'(DEPTH) : UW'(bins_in_use_r);

  // item fields
  logic [5:0]  idx_r;
  logic [31:0] val_r;
  logic        below_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r   <= in_bin_index;
      val_r   <= in_value;
      below_r <= (in_value < lower_limit_r);
    end
  end

  // search and sweep counters
  logic [UW-1:0]    scan_r;
  logic             pend_r;
  logic [IDX_W-1:0] pidx_r;
  logic [IDX_W-1:0] sweep_r;
  logic             scan_more;

  // memories
  logic [31:0]      edge_mem [DEPTH];
  logic [CW-1:0]    cnt_mem  [DEPTH];
  logic [31:0]      edge_rd_r;
  logic [CW-1:0]    cnt_rd_r;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             cnt_we;
  logic [IDX_W-1:0] cnt_waddr;
  logic [CW-1:0]    cnt_wdata;
  logic             hit;

  assign scan_more = (scan_r < used);
  assign hit       = pend_r && !below_r && (val_r <= edge_rd_r);
  assign rd_en     = cmd.load || (cmd.scan && !hit && scan_more);
  assign rd_addr   = cmd.load ? in_bin_index[IDX_W-1:0] : scan_r[IDX_W-1:0];
  assign cnt_we    = cmd.sweep || (cmd.scan && hit);
  assign cnt_waddr = cmd.sweep ? sweep_r : pidx_r;
  assign cnt_wdata = cmd.sweep ? '0 :
                     ((cnt_rd_r == '1) ? cnt_rd_r : cnt_rd_r + 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.load && cmd.edge_wr && ({1'b0, in_bin_index} < 7'(DEPTH))) begin
      edge_mem[in_bin_index[IDX_W-1:0]] <= in_value;
    end
    if (rd_en) begin
      edge_rd_r <= edge_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (rd_en) begin
      cnt_rd_r <= cnt_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r  <= '0;
      pend_r  <= 1'b0;
      sweep_r <= '0;
    end else if (cmd.load) begin
      scan_r  <= '0;
      pend_r  <= 1'b0;
      sweep_r <= '0;
    end else begin
      if (cmd.sweep) begin
        sweep_r <= sweep_r + 1'b1;
      end
      if (cmd.scan && !hit) begin
        pend_r <= scan_more;
        if (scan_more) begin
          scan_r <= scan_r + 1'b1;
          pidx_r <= scan_r[IDX_W-1:0];
        end
      end
    end
  end

  // sample total
  logic [CW-1:0] total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (cmd.total_clr) begin
      total_r <= '0;
    end else if (cmd.total_inc && (total_r != '1)) begin
      total_r <= total_r + 1'b1;
    end
  end

  // read path and restoring divider
  logic              oob;
  logic [CW-1:0]     cnt_eff;
  logic [CW-1:0]     num;
  logic [31:0]       res_edge_r;
  logic [CW-1:0]     res_cnt_r;
  logic              zero_r;
  logic              whole_r;
  logic [CW-1:0]     rem_r;
  logic [FRAC_W-1:0] quo_r;
  logic [STEP_W-1:0] step_r;
  logic [CW:0]       rem_sh;
  logic              rem_ge;
  logic [CW:0]       rem_sub;

  assign oob     = ({1'b0, idx_r} >= 7'(DEPTH));
  assign cnt_eff = oob ? '0 : cnt_rd_r;
  assign num     = (cnt_eff > total_r) ? total_r : cnt_eff;
  assign rem_sh  = {rem_r, 1'b0};
  assign rem_ge  = (rem_sh >= {1'b0, total_r});
  assign rem_sub = rem_sh - {1'b0, total_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      zero_r <= 1'b1;
    end else if (cmd.div_start) begin
      step_r <= '0;
      zero_r <= (cnt_eff == '0) || (total_r == '0);
    end else if (cmd.div_step) begin
      step_r <= step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      res_edge_r <= oob ? 32'd0 : edge_rd_r;
      res_cnt_r  <= cnt_eff;
      whole_r    <= (num == total_r);
      rem_r      <= (num == total_r) ? '0 : num;
      quo_r      <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
      quo_r <= {quo_r[FRAC_W-2:0], rem_ge};
    end
  end

  // output register
  logic                out_valid_r;
  logic [5:0]          out_read_bin_r;
  logic [31:0]         out_edge_value_r;
  logic [31:0]         out_bin_count_r;
  logic [FRAC_W:0]     out_fraction_r;
  logic [CW+31:0]      cnt_ext;

  assign cnt_ext = {32'd0, res_cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_read_bin_r   <= idx_r;
      out_edge_value_r <= res_edge_r;
      out_bin_count_r  <= cnt_ext[31:0];
      out_fraction_r   <= zero_r ? ZERO_FRACTION : {whole_r, quo_r};
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_bin   = out_read_bin_r;
  assign out_edge_value = out_edge_value_r;
  assign out_bin_count  = out_bin_count_r;
  assign out_fraction   = out_fraction_r;

  assign sts.sweep_last = (sweep_r == IDX_W'(DEPTH - 1));
  assign sts.scan_hit   = hit;
  assign sts.scan_end   = below_r || (!pend_r && !scan_more);
  assign sts.div_done   = zero_r || (step_r == DIV_STEPS);
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule

// ----- rtl/lbh_ctrl.sv -----
// histogram controller: item decode and sequencing
`include "log_binned_histogram_defines.svh"

module lbh_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_operation,
  output logic          in_stall,
  input  lbh_pkg::sts_t sts,
  output lbh_pkg::cmd_t cmd
);
  import lbh_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_RDM   = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_RES   = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (op_t'(in_operation))
            OP_CLEAR: begin
              cmd.total_clr = 1'b1;
              state_nxt     = ST_CLEAR;
            end
            OP_WR_EDGE: begin
              cmd.edge_wr = 1'b1;
            end
            OP_ADD: begin
              cmd.total_inc = 1'b1;
              state_nxt     = ST_SCAN;
            end
            OP_READ: begin
              state_nxt = ST_RDM;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_hit || sts.scan_end) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RDM: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_RES;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_RES: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
    endcase
  end

  `LBH_ASSERT_SAME(a_out_load_free, cmd.out_load, sts.out_free, "result loaded over a held result")
  `LBH_ASSERT_NEXT(a_sweep_runs, (state_r == ST_CLEAR) && !sts.sweep_last, state_r == ST_CLEAR, "count sweep cut short")
  `LBH_ASSERT_NEXT(a_div_runs, (state_r == ST_DIV) && !sts.div_done, state_r == ST_DIV, "division left early")
  `LBH_ASSERT_SAME(a_scan_write, sts.scan_hit && (state_r == ST_SCAN), cmd.scan, "bin hit without count update")

endmodule

// ----- rtl/log_binned_histogram.sv -----
// top level of the log-binned histogram engine
// reset: synchronous, rst_n low; then a count sweep zeroes every count entry, stall held high
// clear item: zeroes the total, then the same sweep; write edge item: done in the idle state
// add sample: edge search over up to min(bins_in_use,MAX_BINS,64) bins, one edge compared per cycle
// read bin: out_valid follows the one-bit-per-cycle divider (32 steps);
// the division is skipped when the count or the total is zero; one item in flight at a time
module log_binned_histogram #(
  parameter int unsigned MAX_BINS    = 64,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration writes
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // item input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [5:0]  in_bin_index,
  input  logic [31:0] in_value,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_read_bin,
  output logic [31:0] out_edge_value,
  output logic [31:0] out_bin_count,
  output logic [32:0] out_fraction
);
  import lbh_pkg::*;

  // command and status between sequencing and datapath
  cmd_t cmd;
  sts_t sts;

  // controller decodes each item and walks clear sweep, edge search or divide
  lbh_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  // edge and count tables, total, search counters, divider, output register
  lbh_datapath #(
    .MAX_BINS    (MAX_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_bin_index   (in_bin_index),
    .in_value       (in_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_read_bin   (out_read_bin),
    .out_edge_value (out_edge_value),
    .out_bin_count  (out_bin_count),
    .out_fraction   (out_fraction)
  );

endmodule
